// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and the sextet-to-ASCII map for the Base64 stream encoder.
`default_nettype none
package b64e_pkg;

   localparam int QueueDepth = 2;

   localparam logic [6:0] PadChar = 7'd61;
   localparam logic [6:0] UpperBase = 7'd65;
   localparam logic [6:0] LowerBase = 7'd71;
   localparam logic [6:0] DigitOffset = 7'd4;
   localparam logic [6:0] PlusChar = 7'd43;
   localparam logic [6:0] SlashChar = 7'd47;

   // Characters of one byte, ready to go out; count is 1..4.
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [2:0]      count;
      logic            last;
   } b64e_job_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] ch;
      if (v inside {[6'd0:6'd25]}) begin
         ch = {1'b0, v} + UpperBase;
      end else if (v inside {[6'd26:6'd51]}) begin
         ch = {1'b0, v} + LowerBase;
      end else if (v inside {[6'd52:6'd61]}) begin
         ch = {1'b0, v} - DigitOffset;
      end else if (v == 6'd62) begin
         ch = PlusChar;
      end else begin
         ch = SlashChar;
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// Top level of the Base64 stream encoder: intake, job queue and output serializer.
// The first character of a byte is registered in the job queue and then in the output
//   serializer before it is valid.
// Throughput: one character per cycle while rsp_ready is high, set by the output serializer;
//   a byte gives 1, 2, or 3/4 characters (3/4 for a final byte), 4/3 on average.
// Intake accepts a byte per cycle while the job queue has room (depth QUEUE_DEPTH).
// Reset (synchronous, active high) clears group position, leftover bits, queue and output.
`default_nettype none
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64e_pkg::QueueDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_last_char
);
   import b64e_pkg::*;

   // front -> queue
   logic         fq_valid, fq_ready;
   b64e_job_type fq_job;
   // queue -> back
   logic         qb_valid, qb_ready;
   b64e_job_type qb_job;

   // Intake: each accepted byte beat becomes one job of 1..4 characters.
   b64e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .job_valid     (fq_valid),
      .job_ready     (fq_ready),
      .job           (fq_job)
   );

   // Decouples intake from output so either side can stall alone.
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_job   (fq_job),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_job   (qb_job)
   );

   // Output: one character beat per cycle while the receiver is ready, next job loaded as the last one leaves.
   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (qb_valid),
      .job_ready     (qb_ready),
      .job           (qb_job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
`default_nettype wire

// ===== rtl/b64e_front.sv =====
// Byte intake: tracks group position and leftover bits, builds the characters of each byte.
`default_nettype none
module b64e_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_in_byte,
   input  wire logic                 req_last_byte,
   output logic                      job_valid,
   input  wire logic                 job_ready,
   output b64e_pkg::b64e_job_type    job
);
   import b64e_pkg::*;

   localparam logic [1:0] GroupPos0 = 2'd0;
   localparam logic [1:0] GroupPos1 = 2'd1;
   localparam logic [1:0] GroupPos2 = 2'd2;

   logic [1:0] pos_ff, pos_in;
   logic [3:0] left_ff, left_in;
   logic       take;

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign take      = req_valid && job_ready;

   always_comb begin
      job.chars = '0;
      job.count = 3'd1;
      job.last  = req_last_byte;
      pos_in    = pos_ff;
      left_in   = left_ff;
      case (pos_ff)
         GroupPos1: begin
            job.chars[0] = sextet_char({left_ff[1:0], req_in_byte[7:4]});
            if (req_last_byte) begin
               job.chars[1] = sextet_char({req_in_byte[3:0], 2'b00});
               job.chars[2] = PadChar;
               job.count    = 3'd3;
            end
            pos_in  = GroupPos2;
            left_in = req_in_byte[3:0];
         end
         GroupPos2: begin
            job.chars[0] = sextet_char({left_ff, req_in_byte[7:6]});
            job.chars[1] = sextet_char(req_in_byte[5:0]);
            job.count    = 3'd2;
            pos_in       = GroupPos0;
            left_in      = '0;
         end
         default: begin
            // position 0, and the unused position 3 treated alike
            job.chars[0] = sextet_char(req_in_byte[7:2]);
            if (req_last_byte) begin
               job.chars[1] = sextet_char({req_in_byte[1:0], 4'b0000});
               job.chars[2] = PadChar;
               job.chars[3] = PadChar;
               job.count    = 3'd4;
            end
            pos_in  = GroupPos1;
            left_in = {2'b00, req_in_byte[1:0]};
         end
      endcase
      if (req_last_byte) begin
         pos_in  = GroupPos0;
         left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= GroupPos0;
         left_ff <= '0;
      end else if (take) begin
         pos_ff  <= pos_in;
         left_ff <= left_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/b64e_queue.sv =====
// Short register queue of per-byte character jobs between intake and output.
`default_nettype none
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QueueDepth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_valid,
   output logic                      wr_ready,
   input  wire b64e_pkg::b64e_job_type wr_job,
   output logic                      rd_valid,
   input  wire logic                 rd_ready,
   output b64e_pkg::b64e_job_type    rd_job
);
   import b64e_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   b64e_job_type        slot_ff [DEPTH];
   logic [PtrW-1:0]     wptr_ff, rptr_ff;
   logic [CntW-1:0]     cnt_ff;
   logic                push, pop;

   assign wr_ready = (cnt_ff != FullCnt);
   assign rd_valid = (cnt_ff != '0);
   assign rd_job   = slot_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == LastPtr) ? '0 : wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == LastPtr) ? '0 : rptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/b64e_back.sv =====
// Output serializer: sends the characters of each job one beat at a time.
`default_nettype none
module b64e_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   output logic                      job_ready,
   input  wire b64e_pkg::b64e_job_type job,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [6:0]                rsp_out_char,
   output logic                      rsp_last_char
);
   import b64e_pkg::*;

   b64e_job_type job_ff;
   logic         busy_ff;
   logic [1:0]   idx_ff;
   logic         at_end, fin, load;

   assign at_end = ({1'b0, idx_ff} + 3'd1) == job_ff.count;
   assign fin    = busy_ff && rsp_ready && at_end;
   assign load   = job_valid && (!busy_ff || fin);
   assign job_ready = load;

   assign rsp_valid     = busy_ff;
   assign rsp_out_char  = job_ff.chars[idx_ff];
   assign rsp_last_char = job_ff.last && at_end;

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (fin) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the Base64 stream encoder: directed and random byte streams.
`default_nettype none
module tb;

   // One encoded character as it leaves the block.
   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } encoded_char_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 2000;   // cycles allowed for the pipeline to empty
   localparam int TAIL_CYCLES = 8;      // a margin beyond the encoder latency

   localparam logic [6:0] ASCII_UPPER_A = 7'h41;
   localparam logic [6:0] ASCII_LOWER_A = 7'h61;
   localparam logic [6:0] ASCII_ZERO    = 7'h30;
   localparam logic [6:0] ASCII_PLUS    = 7'h2B;
   localparam logic [6:0] ASCII_SLASH   = 7'h2F;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [6:0] rsp_out_char;
   logic       rsp_last_char;

   // Predictor state: where we are in the 3-byte group, and bits still owed.
   logic [1:0] group_slot;
   logic [3:0] carry_bits;

   encoded_char_type pending_chars[$];   // characters the encoder still owes us

   int send_idle_pct;
   int stall_pct;
   int cycle_count;
   int error_count;
   int bytes_accepted;
   int messages_accepted;
   int chars_checked;

   base64_stream_encoder uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last_char(rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Map a 6-bit sextet onto the standard alphabet.
   function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
      logic [6:0] wide;
      wide = {1'b0, s};
      if (s < 6'd26) begin
         return ASCII_UPPER_A + wide;
      end else if (s < 6'd52) begin
         return ASCII_LOWER_A + (wide - 7'd26);
      end else if (s < 6'd62) begin
         return ASCII_ZERO + (wide - 7'd52);
      end else if (s == 6'd62) begin
         return ASCII_PLUS;
      end
      return ASCII_SLASH;
   endfunction

   task automatic push_char(input logic [6:0] ch, input logic fin);
      encoded_char_type c;
      c.ch = ch;
      c.last = fin;
      pending_chars.push_back(c);
   endtask

   // Work out what one accepted byte must produce and advance the group state.
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      case (group_slot)
         2'd1: begin
            // 2 carried bits plus the high nibble
            push_char(sextet_to_ascii({carry_bits[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               push_char(sextet_to_ascii({b[3:0], 2'b00}), 1'b0);
               push_char(b64e_pkg::PadChar, 1'b1);
            end else begin
               group_slot = 2'd2;
               carry_bits = b[3:0];
            end
         end
         2'd2: begin
            // group closes: two sextets, no padding ever
            push_char(sextet_to_ascii({carry_bits, b[7:6]}), 1'b0);
            push_char(sextet_to_ascii(b[5:0]), fin);
            group_slot = 2'd0;
            carry_bits = 4'd0;
         end
         default: begin
            // slot 0 (slot 3 is unreachable and behaves the same)
            push_char(sextet_to_ascii(b[7:2]), 1'b0);
            if (fin) begin
               push_char(sextet_to_ascii({b[1:0], 4'b0000}), 1'b0);
               push_char(b64e_pkg::PadChar, 1'b0);
               push_char(b64e_pkg::PadChar, 1'b1);
            end else begin
               group_slot = 2'd1;
               carry_bits = {2'b00, b[1:0]};
            end
         end
      endcase
      if (fin) begin
         group_slot = 2'd0;
         carry_bits = 4'd0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: check outgoing beats first, then predict from the incoming
   // beat, all in one process so the order within an edge is fixed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      encoded_char_type want;
      if (reset) begin
         group_slot = 2'd0;
         carry_bits = 4'd0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected character beat: out_char=0x%0h last_char=%0b",
                      rsp_out_char, rsp_last_char);
               error_count++;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_out_char !== want.ch) begin
                  $error("out_char: expected 0x%0h, got 0x%0h", want.ch, rsp_out_char);
                  error_count++;
               end
               if (rsp_last_char !== want.last) begin
                  $error("last_char: expected %0b, got %0b", want.last, rsp_last_char);
                  error_count++;
               end
            end
            chars_checked++;
         end
         if (req_valid && req_ready) begin
            encode_byte(req_in_byte, req_last_byte);
            bytes_accepted++;
            if (req_last_byte) begin
               messages_accepted++;
            end
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** base64_stream_encoder: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Present one byte beat and hold it until the encoder takes it.
   // Valid is only dropped on idle cycles, never between back-to-back beats.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and let every owed character come out.
   task automatic wait_drained();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      if (pending_chars.size() != 0) begin
         $error("%0d characters never came out", pending_chars.size());
         error_count++;
         pending_chars.delete();
      end
   endtask

   // Mostly short messages so every group position meets an ending often;
   // now and then a long one. Bytes lean on the extremes a little.
   task automatic send_random_messages(input int n_bytes);
      int left_to_send;
      int msg_len;
      int k;
      logic [7:0] b;
      left_to_send = n_bytes;
      while (left_to_send > 0) begin
         if ($urandom_range(99) < 80) begin
            msg_len = $urandom_range(1, 6);
         end else begin
            msg_len = $urandom_range(7, 40);
         end
         if (msg_len > left_to_send) begin
            msg_len = left_to_send;
         end
         for (k = 0; k < msg_len; k++) begin
            case ($urandom_range(9))
               0: b = 8'h00;
               1: b = 8'hFF;
               default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, k == msg_len - 1);
         end
         left_to_send -= msg_len;
      end
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Endings at every group position, including one-byte messages.
   task automatic test_message_endings();
      send_byte(8'h00, 1'b1);                   // AA==
      send_byte(8'hFF, 1'b1);                   // /w==
      send_byte(8'h4D, 1'b0);                   // TWE=
      send_byte(8'h61, 1'b1);
      send_byte(8'h4D, 1'b0);                   // TWFu, ends on a full group
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'hFF, 1'b0);                   // full group then a lone last byte
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b1);
      wait_drained();
   endtask

   // Boundaries of each alphabet range: A..D, Z/a, z/0, '+' and '/'.
   task automatic test_alphabet_edges();
      send_byte(8'h00, 1'b0);                   // sextets 0 1 2 3
      send_byte(8'h10, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'h65, 1'b0);                   // sextets 25 26 51 52
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'hFB, 1'b0);                   // all 62
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hAA, 1'b0);                   // sextets 42 47 63 63
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_drained();
   endtask

   // Sender goes quiet mid-group until the encoder has nothing left to say;
   // group state must survive the pause.
   task automatic test_pause_mid_message();
      int k;
      for (k = 0; k < 8; k++) begin
         send_byte(8'($urandom_range(0, 255)), k == 7);
         wait_drained();
      end
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int n_bytes);
      set_idling(sender_pct, receiver_pct);
      send_random_messages(n_bytes);
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_in_byte       = 8'h00;
      req_last_byte     = 1'b0;
      rsp_ready         = 1'b0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      cycle_count       = 0;
      error_count       = 0;
      bytes_accepted    = 0;
      messages_accepted = 0;
      chars_checked     = 0;
      group_slot        = 2'd0;
      carry_bits        = 4'd0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_message_endings();
      test_alphabet_edges();
      test_pause_mid_message();

      test_random_traffic(0, 0, 112);
      test_random_traffic(77, 0, 112);
      test_random_traffic(0, 77, 112);
      test_random_traffic(21, 21, 112);

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d bytes in %0d messages, %0d characters checked,",
               bytes_accepted, messages_accepted, chars_checked);
      $display("with sender gaps and receiver stalls mixed in four traffic phases.");
      if (error_count == 0) begin
         $display("** base64_stream_encoder: PASSED **");
      end else begin
         $display("** base64_stream_encoder: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
